// ===== rtl/ilte_pkg.sv =====
// Package: operation codes and fixed field widths of the indexed list table engine.
`timescale 1ns / 1ps
`default_nettype none
package ilte_pkg;

  localparam int unsigned FuncW  = 3;
  localparam int unsigned PosW   = 5;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;

  // Operation codes; codes 5 to 7 mean nothing and change nothing
  typedef enum logic [FuncW-1:0] {
    FUNC_READ     = 3'd0,
    FUNC_INS_HEAD = 3'd1,
    FUNC_APPEND   = 3'd2,
    FUNC_INS_AT   = 3'd3,
    FUNC_DELETE   = 3'd4
  } func_e;

  // Value returned by a read that misses and by every non-read operation
  localparam logic signed [ValueW-1:0] MissValue = '1;

endpackage
`default_nettype wire

// ===== rtl/ilte_req_if.sv =====
// Interface: request channel carrying one list operation per item.
`timescale 1ns / 1ps
`default_nettype none
interface ilte_req_if;
  import ilte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FuncW-1:0]         func;
  logic [PosW-1:0]          position;
  logic signed [ValueW-1:0] value;

  modport source (output valid, output func, output position, output value, input ready);
  modport sink   (input valid, input func, input position, input value, output ready);

endinterface
`default_nettype wire

// ===== rtl/ilte_rsp_if.sv =====
// Interface: response channel carrying one result per operation.
`timescale 1ns / 1ps
`default_nettype none
interface ilte_rsp_if;
  import ilte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] read_value;
  logic                     read_valid;
  logic                     accepted;
  logic [CountW-1:0]        entry_count;

  modport source (output valid, output read_value, output read_valid, output accepted,
                  output entry_count, input ready);
  modport sink   (input valid, input read_value, input read_valid, input accepted,
                  input entry_count, output ready);

endinterface
`default_nettype wire

// ===== rtl/indexed_list_table_engine.sv =====
// Top level: ordered list of signed values with indexed read, insert and delete.
`timescale 1ns / 1ps
`default_nettype none
// Holds up to CAPACITY signed 32-bit entries in position order in a register array,
// plus a count. Each request item reads, inserts (head, tail or before a position) or
// deletes one entry and gives exactly one response item. An operation is captured in
// an input register, executed combinationally (all entries above the affected place
// shift by one in parallel) and its result lands in an output register, so the block
// takes one item per clock when the response side is not stalled. A response is
// offered once its item moves from the input register to the output register and
// is held there until accepted. Inserts into a full list, positions out of range and
// unknown operation codes leave the list untouched with accepted low; a
// read that misses returns -1 with read_valid low. entry_count shows the low five bits
// of the count after the operation. Entry storage has no reset; count resets to zero.
module indexed_list_table_engine #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  ilte_req_if.sink   req_i,
  ilte_rsp_if.source rsp_o
);
  import ilte_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CmpW-1:0] CapCmp = CmpW'(CAPACITY);

  // Input register
  logic                     s1_valid_q;
  logic [FuncW-1:0]         s1_func_q;
  logic [PosW-1:0]          s1_pos_q;
  logic signed [ValueW-1:0] s1_value_q;

  // Output register
  logic                     out_valid_q;
  logic signed [ValueW-1:0] out_read_value_q, out_read_value_d;
  logic                     out_read_valid_q, out_read_valid_d;
  logic                     out_accepted_q, out_accepted_d;
  logic [CountW-1:0]        out_count_q;

  // List state
  logic [ValueW-1:0] entries_q [CAPACITY];
  logic [CntW-1:0]   count_q, count_d;

  logic            s1_adv;
  logic            take_req;
  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] cnt_ext;
  logic [CmpW-1:0] ins_pos;
  logic [CmpW-1:0] cnt_new;
  logic            do_ins, do_del;
  logic            ins_en, del_en;
  logic [IdxW-1:0] rd_idx;

  // Handshake: the input register frees when its item moves to the output register
  assign s1_adv      = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign take_req    = req_i.valid && req_i.ready;

  // Capture request items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_req) begin
      s1_func_q  <= req_i.func;
      s1_pos_q   <= req_i.position;
      s1_value_q <= req_i.value;
    end
  end

  assign pos_ext = CmpW'(s1_pos_q);
  assign cnt_ext = CmpW'(count_q);
  assign rd_idx  = pos_ext[IdxW-1:0];

  // Decode the operation and form the result
  always_comb begin
    do_ins           = 1'b0;
    do_del           = 1'b0;
    ins_pos          = '0;
    out_read_value_d = MissValue;
    out_read_valid_d = 1'b0;
    case (s1_func_q)
      FUNC_READ: begin
        if (pos_ext < cnt_ext) begin
          out_read_value_d = entries_q[rd_idx];
          out_read_valid_d = 1'b1;
        end
      end
      FUNC_INS_HEAD: begin
        ins_pos = '0;
        do_ins  = (cnt_ext < CapCmp);
      end
      FUNC_APPEND: begin
        ins_pos = cnt_ext;
        do_ins  = (cnt_ext < CapCmp);
      end
      FUNC_INS_AT: begin
        ins_pos = pos_ext;
        do_ins  = (cnt_ext < CapCmp) && (pos_ext <= cnt_ext);
      end
      FUNC_DELETE: begin
        do_del = (pos_ext < cnt_ext);
      end
      default: begin
      end
    endcase
    out_accepted_d = out_read_valid_d || do_ins || do_del;
  end

  assign ins_en = s1_adv && do_ins;
  assign del_en = s1_adv && do_del;

  // Next count
  always_comb begin
    cnt_new = cnt_ext;
    if (do_ins) begin
      cnt_new = cnt_ext + CmpW'(1);
    end else if (do_del) begin
      cnt_new = cnt_ext - CmpW'(1);
    end
    count_d = cnt_new[CntW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (s1_adv) begin
      count_q <= count_d;
    end
  end

  // Shift entries: up for an insert, down for a delete, all places at once
  for (genvar i = 0; i < CAPACITY; i++) begin : g_entry
    localparam logic [CmpW-1:0] Idx     = CmpW'(i);
    localparam logic [CmpW-1:0] IdxNext = CmpW'(i + 1);
    logic [ValueW-1:0] below;
    logic [ValueW-1:0] above;

    if (i == 0) begin : g_first
      assign below = s1_value_q;
    end else begin : g_rest
      assign below = entries_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign above = entries_q[i];
    end else begin : g_inner
      assign above = entries_q[i+1];
    end

    always_ff @(posedge clk_i) begin
      if (ins_en) begin
        if (Idx == ins_pos) begin
          entries_q[i] <= s1_value_q;
        end else if (Idx > ins_pos && Idx <= cnt_ext) begin
          entries_q[i] <= below;
        end
      end else if (del_en) begin
        if (Idx >= pos_ext && IdxNext < cnt_ext) begin
          entries_q[i] <= above;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || rsp_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_read_value_q <= out_read_value_d;
      out_read_valid_q <= out_read_valid_d;
      out_accepted_q   <= out_accepted_d;
      out_count_q      <= cnt_new[CountW-1:0];
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_read_value_q;
  assign rsp_o.read_valid  = out_read_valid_q;
  assign rsp_o.accepted    = out_accepted_q;
  assign rsp_o.entry_count = out_count_q;

endmodule
`default_nettype wire

// ===== rtl/ilte_checker.sv =====
// Checker: port-level properties of the indexed list table engine, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module ilte_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               rsp_valid_i,
  input wire               rsp_ready_i,
  input wire signed [31:0] rsp_read_value_i,
  input wire               rsp_read_valid_i,
  input wire               rsp_accepted_i,
  input wire [4:0]         rsp_entry_count_i
);
  import ilte_pkg::*;

  // Hold a stalled response item
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_value_i)
      && $stable(rsp_read_valid_i) && $stable(rsp_accepted_i) && $stable(rsp_entry_count_i))
    else $error("response item changed while stalled");

  // A read hit always counts as accepted
  a_hit_accepted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_read_valid_i |-> rsp_accepted_i)
    else $error("read hit without accepted");

  // A miss or non-read returns the miss value
  a_miss_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_read_valid_i |-> rsp_read_value_i == MissValue)
    else $error("miss returned a value other than -1");

  // No response right after reset release
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !rsp_valid_i)
    else $error("response valid straight after reset");

endmodule

bind indexed_list_table_engine ilte_checker u_ilte_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_read_value_i  (rsp_o.read_value),
  .rsp_read_valid_i  (rsp_o.read_valid),
  .rsp_accepted_i    (rsp_o.accepted),
  .rsp_entry_count_i (rsp_o.entry_count)
);
`default_nettype wire
